### rtl/core/chs_pkg.sv
// Package for the chained hash set of 32-byte keys.
// Holds the word types, sizing constants and the sequencer state type.
// No dependencies.
package chs_pkg;

  localparam int NodePool   = 4096;
  localparam int MaxBuckets = 1024;
  localparam int NodeW      = $clog2(NodePool);      // node index bits
  localparam int LinkW      = NodeW + 1;             // index plus one, 0 is end
  localparam int BucketW    = $clog2(MaxBuckets);
  localparam int CntW       = 11;
  localparam logic [31:0] CrcPoly = 32'h82F63B78;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic        status;
    logic [11:0] entry_index;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC,
    ST_MOD,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_CHECK,
    ST_KEY_RD,
    ST_KEY_CMP,
    ST_LINK_WAIT,
    ST_ALLOC,
    ST_DONE,
    ST_CLEAR
  } state_t;

endpackage

### rtl/core/chained_hash_set_32byte_keys.sv
// Chained hash set of 32-byte keys: bucket heads, node keys and links in memories; uses chs_pkg.
// Per word: CRC over the four key words, the radix-8 remainder and the head read; then per visited node a
// chain check, four key reads and compares and the link; then an end check, an append of four key
// words and the link (skipped for a find miss or a full pool), and the output register.
// One word at a time; the next is accepted once the result is registered and the sequencer is back in idle.
// Reset: synchronous, active low; a clearing pass empties all bucket heads first.
module chained_hash_set_32byte_keys (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  chs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output chs_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata
);

  localparam int NodeW   = chs_pkg::NodeW;
  localparam int LinkW   = chs_pkg::LinkW;
  localparam int BucketW = chs_pkg::BucketW;
  localparam int CntW    = chs_pkg::CntW;

  // Memories.
  logic [LinkW-1:0] head_mem [chs_pkg::MaxBuckets];
  logic [63:0]      key_mem  [chs_pkg::NodePool*4];
  logic [LinkW-1:0] link_mem [chs_pkg::NodePool];

  chs_pkg::state_t state_r, state_nxt;
  chs_pkg::in_word_t item_r;
  logic [CntW-1:0]    bcount_r;
  logic [31:0]        crc_r, crc_nxt;
  logic [1:0]         wcnt_r, wcnt_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [3:0]         dcnt_r, dcnt_nxt;
  logic [BucketW-1:0] bucket_r;
  logic [LinkW-1:0]   link_r, link_nxt;
  logic [NodeW-1:0]   last_r, last_nxt;
  logic               have_last_r, have_last_nxt;
  logic [LinkW-1:0]   used_r;
  logic               match_r, match_nxt;
  logic [BucketW-1:0] clr_r;
  logic               out_valid_r;
  chs_pkg::out_word_t out_r, res_r, res_nxt;
  logic               load_out;

  logic [LinkW-1:0] head_q, link_q;
  logic [63:0]      key_q;

  // Effective bucket count: zero counts as one, saturated at the maximum.
  logic [CntW-1:0] n_eff;
  always_comb begin
    n_eff = bcount_r;
    if (bcount_r == '0) n_eff = CntW'(1);
    if (bcount_r > CntW'(chs_pkg::MaxBuckets)) n_eff = CntW'(chs_pkg::MaxBuckets);
  end

  // CRC of one 64-bit word, eight bytes of eight bit steps.
  function automatic logic [31:0] crc_word(input logic [31:0] c, input logic [63:0] w);
    logic [31:0] x;
    x = c;
    for (int b = 0; b < 8; b++) begin
      x = x ^ {24'd0, w[8*b +: 8]};
      for (int k = 0; k < 8; k++) begin
        x = (x >> 1) ^ (x[0] ? chs_pkg::CrcPoly : 32'd0);
      end
    end
    return x;
  endfunction

  logic [63:0] cur_word;
  always_comb begin
    case (wcnt_r)
      2'd0:    cur_word = item_r.key_word0;
      2'd1:    cur_word = item_r.key_word1;
      2'd2:    cur_word = item_r.key_word2;
      default: cur_word = item_r.key_word3;
    endcase
  end

  // Radix-8 restoring remainder: three quotient bits per step, 11 steps.
  logic [31:0] rem_ext;
  logic [63:0] dsh;
  always_comb begin
    rem_ext = rem_r;
    dsh     = '0;
    for (int s = 2; s >= 0; s--) begin
      dsh = {53'd0, n_eff} << (33 - 3*int'(dcnt_r) + s);
      if ({32'd0, rem_ext} >= dsh) rem_ext = rem_ext - dsh[31:0];
    end
  end

  logic [NodeW-1:0] node_idx;
  assign node_idx = NodeW'(link_r - LinkW'(1));

  logic key_rd, link_wr, head_wr, key_wr;
  logic [1:0] kidx_r, kidx_nxt;

  always_comb begin
    state_nxt     = state_r;
    crc_nxt       = crc_r;
    wcnt_nxt      = wcnt_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    link_nxt      = link_r;
    last_nxt      = last_r;
    have_last_nxt = have_last_r;
    match_nxt     = match_r;
    kidx_nxt      = kidx_r;
    res_nxt       = res_r;
    load_out      = 1'b0;
    key_wr        = 1'b0;
    link_wr       = 1'b0;
    head_wr       = 1'b0;
    key_rd        = 1'b0;
    case (state_r)
      chs_pkg::ST_CLEAR: begin
        if (clr_r == BucketW'(chs_pkg::MaxBuckets - 1)) state_nxt = chs_pkg::ST_IDLE;
      end
      chs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = chs_pkg::ST_CRC;
          crc_nxt   = '0;
          wcnt_nxt  = '0;
        end
      end
      chs_pkg::ST_CRC: begin
        crc_nxt  = crc_word(crc_r, cur_word);
        wcnt_nxt = wcnt_r + 2'd1;
        if (wcnt_r == 2'd3) begin
          state_nxt = chs_pkg::ST_MOD;
          dcnt_nxt  = '0;
        end
      end
      chs_pkg::ST_MOD: begin
        if (dcnt_r == 4'd0) rem_nxt = crc_r;
        else rem_nxt = rem_ext;
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd11) state_nxt = chs_pkg::ST_HEAD_RD;
      end
      chs_pkg::ST_HEAD_RD: begin
        state_nxt     = chs_pkg::ST_HEAD_WAIT;
        have_last_nxt = 1'b0;
        match_nxt     = 1'b0;
      end
      chs_pkg::ST_HEAD_WAIT: begin
        link_nxt  = head_q;
        state_nxt = chs_pkg::ST_CHECK;
      end
      chs_pkg::ST_CHECK: begin
        kidx_nxt = '0;
        if (link_r == '0 || link_r > LinkW'(chs_pkg::NodePool)) begin
          state_nxt = chs_pkg::ST_ALLOC;
        end else begin
          state_nxt = chs_pkg::ST_KEY_RD;
          match_nxt = 1'b1;
        end
      end
      chs_pkg::ST_KEY_RD: begin
        key_rd    = 1'b1;
        state_nxt = chs_pkg::ST_KEY_CMP;
      end
      chs_pkg::ST_KEY_CMP: begin
        case (kidx_r)
          2'd0:    match_nxt = match_r & (key_q == item_r.key_word0);
          2'd1:    match_nxt = match_r & (key_q == item_r.key_word1);
          2'd2:    match_nxt = match_r & (key_q == item_r.key_word2);
          default: match_nxt = match_r & (key_q == item_r.key_word3);
        endcase
        kidx_nxt = kidx_r + 2'd1;
        if (kidx_r == 2'd3) state_nxt = chs_pkg::ST_LINK_WAIT;
        else state_nxt = chs_pkg::ST_KEY_RD;
      end
      chs_pkg::ST_LINK_WAIT: begin
        if (match_r) begin
          res_nxt   = '{found: 1'b1, status: 1'b0, entry_index: 12'(node_idx)};
          state_nxt = chs_pkg::ST_DONE;
        end else begin
          last_nxt      = node_idx;
          have_last_nxt = 1'b1;
          link_nxt      = link_q;
          state_nxt     = chs_pkg::ST_CHECK;
        end
      end
      chs_pkg::ST_ALLOC: begin
        res_nxt = '{found: 1'b0, status: 1'b0, entry_index: 12'd0};
        if (item_r.operation == chs_pkg::OP_INSERT) begin
          if (used_r >= LinkW'(chs_pkg::NodePool)) begin
            res_nxt.status = 1'b1;
            state_nxt      = chs_pkg::ST_DONE;
          end else begin
            // Four key words, one per cycle; the fourth also writes the tail link or the bucket head.
            key_wr   = 1'b1;
            kidx_nxt = kidx_r + 2'd1;
            if (kidx_r == 2'd3) begin
              link_wr   = have_last_r;
              head_wr   = !have_last_r;
              res_nxt.entry_index = 12'(used_r);
              state_nxt = chs_pkg::ST_DONE;
            end
          end
        end else begin
          state_nxt = chs_pkg::ST_DONE;
        end
      end
      chs_pkg::ST_DONE: begin
        // Wait here while the result register still holds an untaken word.
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = chs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = chs_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == chs_pkg::ST_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chs_pkg::ST_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      bcount_r    <= CntW'(chs_pkg::MaxBuckets);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == chs_pkg::ST_CLEAR) clr_r <= clr_r + BucketW'(1);
      if (cfg_we) bcount_r <= cfg_wdata;
      if (key_wr && kidx_r == 2'd3) used_r <= used_r + LinkW'(1);
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    crc_r       <= crc_nxt;
    wcnt_r      <= wcnt_nxt;
    rem_r       <= rem_nxt;
    dcnt_r      <= dcnt_nxt;
    link_r      <= link_nxt;
    last_r      <= last_nxt;
    have_last_r <= have_last_nxt;
    match_r     <= match_nxt;
    kidx_r      <= kidx_nxt;
    res_r       <= res_nxt;
    if (load_out) out_r <= res_r;
    if (state_r == chs_pkg::ST_MOD && dcnt_r == 4'd11) bucket_r <= BucketW'(rem_ext);
  end

  // Bucket head memory: cleared after reset; read every cycle, the head is taken once per word.
  always_ff @(posedge clk) begin
    if (state_r == chs_pkg::ST_CLEAR) head_mem[clr_r] <= '0;
    else if (head_wr) head_mem[bucket_r] <= LinkW'(used_r + LinkW'(1));
    head_q <= head_mem[bucket_r];
  end

  // Node key memory.
  always_ff @(posedge clk) begin
    if (key_wr) begin
      case (kidx_r)
        2'd0:    key_mem[{NodeW'(used_r), kidx_r}] <= item_r.key_word0;
        2'd1:    key_mem[{NodeW'(used_r), kidx_r}] <= item_r.key_word1;
        2'd2:    key_mem[{NodeW'(used_r), kidx_r}] <= item_r.key_word2;
        default: key_mem[{NodeW'(used_r), kidx_r}] <= item_r.key_word3;
      endcase
    end
    if (key_rd) key_q <= key_mem[{node_idx, kidx_r}];
  end

  // Node link memory: new node gets end of chain, old tail points at it.
  always_ff @(posedge clk) begin
    if (key_wr && kidx_r == 2'd0) link_mem[NodeW'(used_r)] <= '0;
    else if (link_wr) link_mem[last_r] <= LinkW'(used_r + LinkW'(1));
    link_q <= link_mem[node_idx];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == chs_pkg::ST_IDLE) else $error("ready outside idle");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= LinkW'(chs_pkg::NodePool)) else $error("pool count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(out_r)) else $error("result changed");
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && res_r.status |-> !res_r.found) else $error("full and found");
`endif

endmodule
